/* rtl/iff_pkg.sv */
// Shared constants, codes and the digit character lookup for the
// integer field formatter. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iff_pkg;

    localparam int MAX_FIELD  = 40;
    localparam int OUT_LIMIT  = MAX_FIELD + 1;
    localparam int ARG_W      = 32;
    localparam int NUM_DIGITS = 12;
    localparam int DIG_IDX_W  = $clog2(NUM_DIGITS);
    localparam int BIT_CNT_W  = $clog2(ARG_W);
    localparam int LEN_W      = $clog2(2 * MAX_FIELD + NUM_DIGITS + 4);
    localparam int FW_W       = 6;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 8;

    localparam logic [2:0] CONV_C  = 3'd0;
    localparam logic [2:0] CONV_D  = 3'd1;
    localparam logic [2:0] CONV_O  = 3'd2;
    localparam logic [2:0] CONV_U  = 3'd3;
    localparam logic [2:0] CONV_X  = 3'd4;
    localparam logic [2:0] CONV_XU = 3'd5;
    localparam logic [2:0] CONV_P  = 3'd6;
    localparam logic [2:0] CONV_BAD = 3'd7;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_SPACE = 2'd1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_A_LO  = 8'h61;

    typedef logic [3:0] digit_t;

    function automatic logic [7:0] digit_char(input digit_t d, input logic upper);
        logic [7:0] base_ch;
        base_ch = upper ? CH_A_UP : CH_A_LO;
        if (d < 4'd10) begin
            return CH_ZERO + {4'd0, d};
        end else begin
            return base_ch + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/integer_field_formatter.sv */
// Sequence: a numeric conversion passes through the accept state, bit-serial
// digit conversion in S_CONV (one argument bit per cycle) and the layout states
// S_SIZE, S_PAD and S_BOUND before its first character; a literal or %c item skips S_CONV.
// Throughput: one character per cycle on the output while m_axis_tready is high; an
// item holds the block until its last character is loaded, N <= 41 characters.
// Reset: synchronous active-low aresetn clears the sequencer and output valid.
// Depends on iff_pkg.
`timescale 1ns / 1ps
`default_nettype none

module integer_field_formatter (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // literal_char[7:0] conversion[10:8] short_arg[11] alt_form[12]
    // left_adjust[13] zero_pad[14] sign_mode[16:15] field_width[22:17]
    // min_digits[29:23] arg_value[61:30], zero fill above
    input  wire logic [iff_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // op[0]
    input  wire logic [0:0]                     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // out_char[7:0]
    output logic [iff_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    output logic                                m_axis_tlast
);
    import iff_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CONV  = 3'd1;
    localparam logic [2:0] S_SIZE  = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_BOUND = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // input fields
    logic [7:0]       in_lit;
    logic [2:0]       in_cv;
    logic             in_short, in_alt, in_left, in_zpad;
    logic [1:0]       in_sm;
    logic [FW_W-1:0]  in_fw;
    logic [6:0]       in_md;
    logic [ARG_W-1:0] in_arg;

    assign in_lit   = s_axis_tdata[7:0];
    assign in_cv    = s_axis_tdata[10:8];
    assign in_short = s_axis_tdata[11];
    assign in_alt   = s_axis_tdata[12];
    assign in_left  = s_axis_tdata[13];
    assign in_zpad  = s_axis_tdata[14];
    assign in_sm    = s_axis_tdata[16:15];
    assign in_fw    = s_axis_tdata[22:17];
    assign in_md    = s_axis_tdata[29:23];
    assign in_arg   = s_axis_tdata[61:30];

    logic [2:0]                       state_reg, state_next;
    logic [2:0]                       cv_reg, cv_next;
    logic [7:0]                       chr_reg, chr_next;
    logic [ARG_W-1:0]                 sh_reg, sh_next;
    logic [NUM_DIGITS-1:0][3:0]       dig_reg, dig_next;
    logic [BIT_CNT_W-1:0]             bit_cnt_reg, bit_cnt_next;
    logic                             left_reg, left_next;
    logic                             zpad_reg, zpad_next;
    logic                             alt_reg, alt_next;
    logic [FW_W-1:0]                  width_reg, width_next;
    logic [FW_W-1:0]                  prec_reg, prec_next;
    logic                             prec0_reg, prec0_next;
    logic                             sign_reg, sign_next;
    logic [7:0]                       sign_char_reg, sign_char_next;
    logic [DIG_IDX_W:0]               size_reg, size_next;
    logic                             hexpfx_reg, hexpfx_next;
    logic [LEN_W-1:0]                 pad_reg, pad_next;
    logic [LEN_W-1:0]                 pz_reg, pz_next;
    logic [LEN_W-1:0]                 b1_reg, b1_next, b2_reg, b2_next, b3_reg, b3_next;
    logic [LEN_W-1:0]                 b4_reg, b4_next, b5_reg, b5_next, b6_reg, b6_next;
    logic [LEN_W-1:0]                 len_reg, len_next;
    logic [LEN_W-1:0]                 n_reg, n_next;
    logic                             m_valid_reg, m_valid_next;
    logic [7:0]                       m_data_reg, m_data_next;
    logic                             m_last_reg, m_last_next;

    // accept-side preparation
    logic             accept;
    logic [ARG_W-1:0] arg_narrow, arg_abs;
    logic             arg_neg, prec_given, numeric;
    logic [FW_W-1:0]  prec_sat, width_sat;

    // conversion step
    logic [4:0]            base;
    logic [3:0]            half;
    logic [NUM_DIGITS-1:0] carry;
    logic [NUM_DIGITS-1:0] carry_in;
    logic [NUM_DIGITS-1:0][3:0] dig_step;

    // size, layout and character select
    logic [DIG_IDX_W:0]   k_cnt;
    logic [LEN_W-1:0]     size_w, prec_w, body, realsz;
    logic [LEN_W-1:0]     di_full;
    logic [DIG_IDX_W-1:0] di;
    digit_t               cur_digit;
    logic [7:0]           cur_char;
    logic                 load_out;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    always_comb begin
        if (in_short && in_cv != CONV_P) begin
            if (in_cv == CONV_D && in_arg[15]) begin
                arg_narrow = {16'hFFFF, in_arg[15:0]};
            end else begin
                arg_narrow = {16'h0000, in_arg[15:0]};
            end
        end else begin
            arg_narrow = in_arg;
        end
        arg_neg    = (in_cv == CONV_D) && arg_narrow[ARG_W-1];
        arg_abs    = arg_neg ? (ARG_W'(0) - arg_narrow) : arg_narrow;
        numeric    = (in_cv != CONV_C);
        prec_given = !in_md[6];
        prec_sat   = (in_md[5:0] > FW_W'(MAX_FIELD)) ? FW_W'(MAX_FIELD) : in_md[5:0];
        width_sat  = (in_fw > FW_W'(MAX_FIELD)) ? FW_W'(MAX_FIELD) : in_fw;
    end

    always_comb begin
        case (cv_reg)
            CONV_D, CONV_U: base = 5'd10;
            CONV_O:         base = 5'd8;
            default:        base = 5'd16;
        endcase
        half = base[4:1];
        for (int i = 0; i < NUM_DIGITS; i++) begin
            carry[i] = (dig_reg[i] >= half);
        end
        carry_in = {carry[NUM_DIGITS-2:0], sh_reg[ARG_W-1]};
        for (int i = 0; i < NUM_DIGITS; i++) begin
            dig_step[i] = 4'(({dig_reg[i], carry_in[i]})
                             - (carry[i] ? base : 5'd0));
        end
    end

    always_comb begin
        k_cnt = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (dig_reg[i] != 4'd0) begin
                k_cnt = (DIG_IDX_W + 1)'(i + 1);
            end
        end
    end

    always_comb begin
        size_w = LEN_W'(size_reg);
        prec_w = LEN_W'(prec_reg);
        body   = (prec_w > size_w) ? prec_w : size_w;
        realsz = body + LEN_W'(sign_reg) + (hexpfx_reg ? LEN_W'(2) : LEN_W'(0));
    end

    always_comb begin
        di_full   = b6_reg - LEN_W'(1) - n_reg;
        di        = di_full[DIG_IDX_W-1:0];
        cur_digit = (di_full < LEN_W'(NUM_DIGITS)) ? dig_reg[di] : 4'd0;
        if (n_reg < b1_reg) begin
            cur_char = CH_SPACE;
        end else if (n_reg < b2_reg) begin
            cur_char = sign_char_reg;
        end else if (n_reg < b3_reg) begin
            cur_char = (n_reg == b2_reg) ? CH_ZERO
                     : ((cv_reg == CONV_XU) ? CH_X_UP : CH_X_LO);
        end else if (n_reg < b5_reg) begin
            cur_char = CH_ZERO;
        end else if (n_reg < b6_reg) begin
            cur_char = (cv_reg == CONV_C) ? chr_reg
                     : digit_char(cur_digit, cv_reg == CONV_XU);
        end else begin
            cur_char = CH_SPACE;
        end
    end

    assign load_out = !m_valid_reg || m_axis_tready;

    always_comb begin
        state_next     = state_reg;
        cv_next        = cv_reg;
        chr_next       = chr_reg;
        sh_next        = sh_reg;
        dig_next       = dig_reg;
        bit_cnt_next   = bit_cnt_reg;
        left_next      = left_reg;
        zpad_next      = zpad_reg;
        alt_next       = alt_reg;
        width_next     = width_reg;
        prec_next      = prec_reg;
        prec0_next     = prec0_reg;
        sign_next      = sign_reg;
        sign_char_next = sign_char_reg;
        size_next      = size_reg;
        hexpfx_next    = hexpfx_reg;
        pad_next       = pad_reg;
        pz_next        = pz_reg;
        b1_next        = b1_reg;
        b2_next        = b2_reg;
        b3_next        = b3_reg;
        b4_next        = b4_reg;
        b5_next        = b5_reg;
        b6_next        = b6_reg;
        len_next       = len_reg;
        n_next         = n_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;

        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    sh_next      = arg_abs;
                    dig_next     = '0;
                    bit_cnt_next = '0;
                    hexpfx_next  = 1'b0;
                    if (!s_axis_tuser[0]) begin
                        // literal: same path as %c with no flags
                        cv_next    = CONV_C;
                        chr_next   = in_lit;
                        left_next  = 1'b0;
                        zpad_next  = 1'b0;
                        alt_next   = 1'b0;
                        width_next = '0;
                        prec_next  = '0;
                        prec0_next = 1'b0;
                        sign_next  = 1'b0;
                        state_next = S_SIZE;
                    end else if (in_cv != CONV_BAD) begin
                        cv_next        = in_cv;
                        chr_next       = in_arg[7:0];
                        left_next      = in_left;
                        zpad_next      = in_zpad && !(numeric && prec_given);
                        alt_next       = in_alt;
                        width_next     = width_sat;
                        prec_next      = (numeric && prec_given) ? prec_sat : '0;
                        prec0_next     = prec_given && (prec_sat == '0);
                        sign_next      = (in_cv == CONV_D) && (arg_neg || in_sm != SIGN_NONE);
                        sign_char_next = arg_neg ? CH_MINUS
                                       : ((in_sm == SIGN_SPACE) ? CH_SPACE : CH_PLUS);
                        state_next     = numeric ? S_CONV : S_SIZE;
                    end
                end
            end
            S_CONV: begin
                dig_next     = dig_step;
                sh_next      = {sh_reg[ARG_W-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(ARG_W - 1)) begin
                    state_next = S_SIZE;
                end
            end
            S_SIZE: begin
                if (cv_reg == CONV_C) begin
                    size_next = (DIG_IDX_W + 1)'(1);
                end else if (k_cnt == '0) begin
                    size_next = prec0_reg ? '0 : (DIG_IDX_W + 1)'(1);
                end else if (cv_reg == CONV_O && alt_reg) begin
                    size_next = k_cnt + (DIG_IDX_W + 1)'(1);
                end else begin
                    size_next = k_cnt;
                end
                hexpfx_next = (cv_reg == CONV_X || cv_reg == CONV_XU) && alt_reg
                              && (k_cnt != '0);
                state_next  = S_PAD;
            end
            S_PAD: begin
                pad_next   = (LEN_W'(width_reg) > realsz) ? LEN_W'(width_reg) - realsz
                                                          : LEN_W'(0);
                pz_next    = (prec_w > size_w) ? prec_w - size_w : LEN_W'(0);
                // total length is the wider of field width and realsz (body, sign, prefix); clip at the limit
                if (LEN_W'(width_reg) > realsz) begin
                    len_next = LEN_W'(width_reg);
                end else begin
                    len_next = realsz;
                end
                if (len_next > LEN_W'(OUT_LIMIT)) begin
                    len_next = LEN_W'(OUT_LIMIT);
                end
                state_next = S_BOUND;
            end
            S_BOUND: begin
                b1_next = (!left_reg && !zpad_reg) ? pad_reg : LEN_W'(0);
                b2_next = b1_next + LEN_W'(sign_reg);
                b3_next = b2_next + (hexpfx_reg ? LEN_W'(2) : LEN_W'(0));
                b4_next = b3_next + ((!left_reg && zpad_reg) ? pad_reg : LEN_W'(0));
                b5_next = b4_next + pz_reg;
                b6_next = b5_next + size_w;
                n_next  = '0;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (len_reg == '0) begin
                    state_next = S_IDLE;
                end else if (load_out) begin
                    m_valid_next = 1'b1;
                    m_data_next  = cur_char;
                    m_last_next  = (n_reg == len_reg - LEN_W'(1));
                    n_next       = n_reg + LEN_W'(1);
                    if (n_reg == len_reg - LEN_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cv_reg        <= cv_next;
        chr_reg       <= chr_next;
        sh_reg        <= sh_next;
        dig_reg       <= dig_next;
        bit_cnt_reg   <= bit_cnt_next;
        left_reg      <= left_next;
        zpad_reg      <= zpad_next;
        alt_reg       <= alt_next;
        width_reg     <= width_next;
        prec_reg      <= prec_next;
        prec0_reg     <= prec0_next;
        sign_reg      <= sign_next;
        sign_char_reg <= sign_char_next;
        size_reg      <= size_next;
        hexpfx_reg    <= hexpfx_next;
        pad_reg       <= pad_next;
        pz_reg        <= pz_next;
        b1_reg        <= b1_next;
        b2_reg        <= b2_next;
        b3_reg        <= b3_next;
        b4_reg        <= b4_next;
        b5_reg        <= b5_next;
        b6_reg        <= b6_next;
        len_reg       <= len_next;
        n_reg         <= n_next;
        m_data_reg    <= m_data_next;
        m_last_reg    <= m_last_next;
    end

    a_layout_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) |-> (b1_reg <= b2_reg && b2_reg <= b3_reg &&
                                   b3_reg <= b4_reg && b4_reg <= b5_reg &&
                                   b5_reg <= b6_reg))
        else $error("character layout boundaries out of order");

    a_len_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && n_reg != '0) |-> (n_reg < len_reg &&
                                                  len_reg <= LEN_W'(OUT_LIMIT)))
        else $error("character index beyond clipped length");

    a_pending_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (state_reg == S_EMIT))
        else $error("item released before its last character");

    a_literal_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_axis_tuser[0]) |=> (state_reg == S_SIZE && cv_reg == CONV_C))
        else $error("literal did not bypass conversion");

endmodule

`default_nettype wire
